/* sv/bcp_pkg.sv */
// Shared constants, types and tables for the beacon constellation pose core.
`default_nettype none
package bcp_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int StepsUsed = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int StepW = $clog2(StepsUsed + 1);
    localparam int VW = 40;          // vector datapath width
    localparam int ZW = 28;          // angle accumulator width
    localparam logic [9:0] NotSeen = 10'd1023;
    localparam logic signed [ZW-1:0] HalfPi = 28'sd26353589;
    localparam logic signed [17:0] InvGain = 18'sd39797;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] c;
    } t_pick;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0: r = 28'sd13176795;
            5'd1: r = 28'sd7778716;
            5'd2: r = 28'sd4110060;
            5'd3: r = 28'sd2086331;
            5'd4: r = 28'sd1047214;
            5'd5: r = 28'sd524117;
            5'd6: r = 28'sd262123;
            5'd7: r = 28'sd131069;
            default: r = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* sv/bcp_select.sv */
// Pair search: longest and second-longest pair, one pair per cycle.
`default_nettype none
module bcp_select (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [3:0][9:0]     i_px,
    input  wire logic [3:0][9:0]     i_py,
    output logic                     o_done,
    output bcp_pkg::t_pick           o_pick
);
    import bcp_pkg::*;
    logic [2:0] r_k;
    logic       r_busy;
    logic [1:0] r_m1, r_m2, r_s1, r_s2;
    logic [21:0] r_dmax, r_d2;
    logic [1:0] pi_i, pi_j;
    logic signed [10:0] ex, ey;
    logic signed [21:0] sq_x, sq_y;
    logic [21:0] d;

    always_comb begin
        case (r_k)
            3'd0: begin pi_i = 2'd0; pi_j = 2'd1; end
            3'd1: begin pi_i = 2'd0; pi_j = 2'd2; end
            3'd2: begin pi_i = 2'd0; pi_j = 2'd3; end
            3'd3: begin pi_i = 2'd1; pi_j = 2'd2; end
            3'd4: begin pi_i = 2'd1; pi_j = 2'd3; end
            default: begin pi_i = 2'd2; pi_j = 2'd3; end
        endcase
        ex = $signed({1'b0, i_px[pi_i]}) - $signed({1'b0, i_px[pi_j]});
        ey = $signed({1'b0, i_py[pi_i]}) - $signed({1'b0, i_py[pi_j]});
        // Square at full width; both squares together still fit 22 bits.
        sq_x = ex * ex;
        sq_y = ey * ey;
        d = $unsigned(sq_x + sq_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k <= '0;
                r_m1 <= 2'd0; r_m2 <= 2'd1; r_s1 <= 2'd0; r_s2 <= 2'd2;
                r_dmax <= '0; r_d2 <= '0;
            end else if (r_busy) begin
                if (d > r_dmax) begin
                    r_s1 <= r_m1; r_s2 <= r_m2; r_d2 <= r_dmax;
                    r_m1 <= pi_i; r_m2 <= pi_j; r_dmax <= d;
                end else if (d > r_d2) begin
                    r_s1 <= pi_i; r_s2 <= pi_j; r_d2 <= d;
                end
                r_k <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_m1 == r_s1 || r_m1 == r_s2) begin
            o_pick.c = r_m1; o_pick.a = r_m2;
        end else begin
            o_pick.c = r_m2; o_pick.a = r_m1;
        end
    end
endmodule
`default_nettype wire

/* sv/bcp_cordic.sv */
// Iterative vectoring CORDIC that also rotates the midpoint vector.
`default_nettype none
module bcp_cordic (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [bcp_pkg::VW-1:0] i_x,
    input  wire logic signed [bcp_pkg::VW-1:0] i_y,
    input  wire logic signed [bcp_pkg::VW-1:0] i_u,
    input  wire logic signed [bcp_pkg::VW-1:0] i_v,
    output logic                               o_done,
    output logic signed [bcp_pkg::VW-1:0]      o_u,
    output logic signed [bcp_pkg::VW-1:0]      o_v,
    output logic signed [bcp_pkg::ZW-1:0]      o_z
);
    import bcp_pkg::*;
    logic signed [VW-1:0] r_x, r_y;
    logic [StepW-1:0] r_i;
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                o_z <= '0;
                if (i_x == 0 && i_y == 0) begin
                    r_x <= i_x; r_y <= i_y; o_u <= i_u; o_v <= i_v;
                    o_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x < 0 && i_y >= 0) begin
                        r_x <= i_y; r_y <= -i_x; o_u <= i_v; o_v <= -i_u;
                        o_z <= HalfPi;
                    end else if (i_x < 0) begin
                        r_x <= -i_y; r_y <= i_x; o_u <= -i_v; o_v <= i_u;
                        o_z <= -HalfPi;
                    end else begin
                        r_x <= i_x; r_y <= i_y; o_u <= i_u; o_v <= i_v;
                    end
                end
            end else if (r_busy) begin
                if (r_i == StepW'(StepsUsed)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    if (r_y >= 0) begin
                        r_x <= r_x + (r_y >>> r_i); r_y <= r_y - (r_x >>> r_i);
                        o_u <= o_u + (o_v >>> r_i); o_v <= o_v - (o_u >>> r_i);
                        o_z <= o_z + atan_q24(5'(r_i));
                    end else begin
                        r_x <= r_x - (r_y >>> r_i); r_y <= r_y + (r_x >>> r_i);
                        o_u <= o_u - (o_v >>> r_i); o_v <= o_v + (o_u >>> r_i);
                        o_z <= o_z - atan_q24(5'(r_i));
                    end
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/beacon_constellation_pose_core.sv */
// Top level of the beacon constellation pose core.
// Sequence: a missed frame goes straight to its result beat; a seen frame passes
// through pair search, set-up, the CORDIC steps and gain, saturation and output
// (the CORDIC returns without iterating when the anchor and far point coincide).
// Throughput: one frame at a time; the next frame is taken only after the result
// beat leaves.
// Reset: synchronous, active low; clears the held pose to zero and the sequencer.
`default_nettype none
module beacon_constellation_pose_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [9:0]         i_p0_x,
    input  wire logic [9:0]         i_p1_x,
    input  wire logic [9:0]         i_p2_x,
    input  wire logic [9:0]         i_p3_x,
    input  wire logic [9:0]         i_p0_y,
    input  wire logic [9:0]         i_p1_y,
    input  wire logic [9:0]         i_p2_y,
    input  wire logic [9:0]         i_p3_y,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [14:0]      o_field_x,
    output logic signed [14:0]      o_field_y,
    output logic signed [15:0]      o_heading,
    output logic                    o_missed
);
    import bcp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEL   = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_CORD  = 7'b0001000,
        S_MULU  = 7'b0010000,
        S_MULV  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [3:0][9:0] r_px, r_py;
    logic r_sel_go, r_cord_go;
    logic sel_done, cord_done;
    t_pick pick;
    logic signed [VW-1:0] r_cx, r_cy, r_cu, r_cv;
    logic signed [VW-1:0] cu, cv;
    logic signed [ZW-1:0] cz;
    logic signed [VW-1:0] r_mop;      // operand of the shared gain multiplier
    logic signed [VW+18-1:0] prod;
    logic signed [14:0] r_held_x, r_held_y;
    logic signed [15:0] r_held_h;
    logic miss;
    logic signed [ZW-1:0] hz;
    logic signed [ZW-13:0] hq;

    // Hold off input in reset, while a frame is in work and while a beat waits.
    assign o_stall = !i_rst_n || (r_state != S_IDLE) || o_valid;
    assign miss = (i_p0_x == NotSeen) || (i_p1_x == NotSeen) || (i_p2_x == NotSeen)
               || (i_p3_x == NotSeen) || (i_p0_y == NotSeen) || (i_p1_y == NotSeen)
               || (i_p2_y == NotSeen) || (i_p3_y == NotSeen);

    bcp_select u_sel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sel_go),
        .i_px(r_px), .i_py(r_py), .o_done(sel_done), .o_pick(pick)
    );

    bcp_cordic u_cord (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cord_go),
        .i_x(r_cx), .i_y(r_cy), .i_u(r_cu), .i_v(r_cv),
        .o_done(cord_done), .o_u(cu), .o_v(cv), .o_z(cz)
    );

    // Round the product by 2^31, floor-shift by 32, negate when asked; saturate to 15 bits.
    function automatic logic signed [14:0] gain_sat(input logic signed [VW+18-1:0] p,
                                                    input logic neg);
        logic signed [VW+18-1:0] q;
        logic signed [VW+18-1:0] r;
        q = (p + (58'sd1 <<< 31)) >>> 32;
        r = neg ? -q : q;
        if (r > 58'sd16383) return 15'sd16383;
        if (r < -58'sd16384) return -15'sd16384;
        return r[14:0];
    endfunction

    assign prod = r_mop * InvGain;
    assign hz = cz - HalfPi + 28'sd2048;
    assign hq = hz[ZW-1:12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_sel_go <= 1'b0;
            r_cord_go <= 1'b0;
            r_held_x <= '0;
            r_held_y <= '0;
            r_held_h <= '0;
        end else begin
            r_sel_go <= 1'b0;
            r_cord_go <= 1'b0;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_px <= {i_p3_x, i_p2_x, i_p1_x, i_p0_x};
                        r_py <= {i_p3_y, i_p2_y, i_p1_y, i_p0_y};
                        if (miss) begin
                            o_missed <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            o_missed <= 1'b0;
                            r_sel_go <= 1'b1;
                            r_state <= S_SEL;
                        end
                    end
                end
                S_SEL: begin
                    if (sel_done) begin
                        // Scale the difference by 2^16; centre the midpoint on (512, 384) and scale it by 2^20.
                        r_cx <= VW'($signed({1'b0, r_px[pick.a]}) -
                                    $signed({1'b0, r_px[pick.c]})) <<< 16;
                        r_cy <= VW'($signed({1'b0, r_py[pick.a]}) -
                                    $signed({1'b0, r_py[pick.c]})) <<< 16;
                        r_cu <= ((VW'(r_px[pick.a]) + VW'(r_px[pick.c])) * 8 - 8192) <<< 16;
                        r_cv <= ((VW'(r_py[pick.a]) + VW'(r_py[pick.c])) * 8 - 6144) <<< 16;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_cord_go <= 1'b1;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (cord_done) begin
                        r_mop <= cv;
                        if (hq > 17'sd6434) r_held_h <= 16'sd6434;
                        else if (hq < -17'sd19302) r_held_h <= -16'sd19302;
                        else r_held_h <= hq[15:0];
                        r_state <= S_MULU;
                    end
                end
                S_MULU: begin
                    r_held_x <= gain_sat(prod, 1'b0);
                    r_mop <= cu;
                    r_state <= S_MULV;
                end
                S_MULV: begin
                    r_held_y <= gain_sat(prod, 1'b1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_field_x = r_held_x;
    assign o_field_y = r_held_y;
    assign o_heading = r_held_h;
endmodule
`default_nettype wire

/* sv/bcp_checker.sv */
// Port-level checker for the beacon constellation pose core, with its bind.
`default_nettype none
module bcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_heading,
    input wire logic        o_missed
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_heading))
        else $error("stalled beat changed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a beat waits");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accept");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_missed |-> ($signed(o_heading) <= 16'sd6434 &&
                                  $signed(o_heading) >= -16'sd19302))
        else $error("heading out of range");
endmodule

bind beacon_constellation_pose_core bcp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_heading(o_heading), .o_missed(o_missed)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the beacon constellation pose core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bcp_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int ArcTab [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct packed {
        logic [9:0] x0, x1, x2, x3, y0, y1, y2, y3;
    } t_frame;

    typedef struct packed {
        logic signed [14:0] fx;
        logic signed [14:0] fy;
        logic signed [15:0] hd;
        logic               miss;
    } t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_missed;
    logic [9:0] px0 = '0, px1 = '0, px2 = '0, px3 = '0;
    logic [9:0] py0 = '0, py1 = '0, py2 = '0, py3 = '0;
    logic signed [14:0] o_field_x, o_field_y;
    logic signed [15:0] o_heading;

    beacon_constellation_pose_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_p0_x(px0), .i_p1_x(px1), .i_p2_x(px2), .i_p3_x(px3),
        .i_p0_y(py0), .i_p1_y(py1), .i_p2_y(py2), .i_p3_y(py3),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_field_x(o_field_x), .o_field_y(o_field_y),
        .o_heading(o_heading), .o_missed(o_missed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: the pose held across missed frames.
    logic signed [14:0] pose_x = '0, pose_y = '0;
    logic signed [15:0] pose_hd = '0;

    t_frame frames_to_send[$];
    t_pose  poses_due[$];
    int     send_idle_pct = 0, recv_idle_pct = 0;
    bit     send_hold = 1'b0, recv_hold = 1'b0;
    int     fails = 0, checked = 0, missed_seen = 0;
    longint cycles = 0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Work out the pose that one frame gives, and update the held pose.
    function automatic t_pose solve_pose(t_frame f);
        int xs[4], ys[4];
        int m1, m2, s1, s2, c, a, ex, ey, n;
        longint d, dmax, d2max, x, y, u, v, z, t, xd, yd, ud, vd, h;
        t_pose r;
        xs = '{f.x0, f.x1, f.x2, f.x3};
        ys = '{f.y0, f.y1, f.y2, f.y3};
        r.miss = 1'b0;
        for (int k = 0; k < 4; k++)
            if (xs[k] == NotSeen || ys[k] == NotSeen) r.miss = 1'b1;
        if (!r.miss) begin
            m1 = 0; m2 = 1; s1 = 0; s2 = 2; dmax = 0; d2max = 0;
            for (int i = 0; i <= 2; i++)
                for (int j = i + 1; j <= 3; j++) begin
                    ex = xs[i] - xs[j]; ey = ys[i] - ys[j];
                    d = longint'(ex * ex) + longint'(ey * ey);
                    if (d > dmax) begin
                        s1 = m1; s2 = m2; d2max = dmax;
                        m1 = i; m2 = j; dmax = d;
                    end else if (d > d2max) begin
                        s1 = i; s2 = j; d2max = d;
                    end
                end
            if (m1 == s1 || m1 == s2) begin c = m1; a = m2; end
            else begin c = m2; a = m1; end
            x = longint'(xs[a] - xs[c]) * 65536;
            y = longint'(ys[a] - ys[c]) * 65536;
            u = (longint'(xs[a] + xs[c]) * 8 - 8192) * 65536;
            v = (longint'(ys[a] + ys[c]) * 8 - 6144) * 65536;
            z = 0;
            if (x != 0 || y != 0) begin
                if (x < 0) begin
                    if (y >= 0) begin
                        t = x; x = y; y = -t; t = u; u = v; v = -t; z = HalfPi;
                    end else begin
                        t = x; x = -y; y = t; t = u; u = -v; v = t; z = -HalfPi;
                    end
                end
                n = CORDIC_STEPS < 24 ? CORDIC_STEPS : 24;
                for (int i = 0; i < n; i++) begin
                    xd = fshr(x, i); yd = fshr(y, i); ud = fshr(u, i); vd = fshr(v, i);
                    if (y >= 0) begin
                        x += yd; y -= xd; u += vd; v -= ud; z += ArcTab[i];
                    end else begin
                        x -= yd; y += xd; u -= vd; v += ud; z -= ArcTab[i];
                    end
                end
            end
            h = fshr(z - HalfPi + 2048, 12);
            pose_hd = 16'(clip(h, -19302, 6434));
            pose_x = 15'(clip(fshr(v * 39797 + (64'sd1 << 31), 32), -16384, 16383));
            pose_y = 15'(clip(-fshr(u * 39797 + (64'sd1 << 31), 32), -16384, 16383));
        end
        r.fx = pose_x; r.fy = pose_y; r.hd = pose_hd;
        return r;
    endfunction

    function automatic logic [9:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1022;
            2: return NotSeen;
            default: return 10'($urandom_range(0, 1022));
        endcase
    endfunction

    function automatic t_frame rand_frame(bit allow_miss);
        t_frame f;
        f = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        // Most frames see all four beacons so the pose path is exercised.
        if (!allow_miss) begin
            if (f.x0 == NotSeen) f.x0 = 10'd1022;
            if (f.x1 == NotSeen) f.x1 = 10'd1022;
            if (f.x2 == NotSeen) f.x2 = 10'd1022;
            if (f.x3 == NotSeen) f.x3 = 10'd1022;
            if (f.y0 == NotSeen) f.y0 = 10'd1022;
            if (f.y1 == NotSeen) f.y1 = 10'd1022;
            if (f.y2 == NotSeen) f.y2 = 10'd1022;
            if (f.y3 == NotSeen) f.y3 = 10'd1022;
        end
        return f;
    endfunction

    // Driver: present the head of the queue; predict the pose when a beat is taken.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                poses_due.push_back(solve_pose({px0, px1, px2, px3, py0, py1, py2, py3}));
                void'(frames_to_send.pop_front());
            end
            if ((!i_valid || !o_stall) && frames_to_send.size() > 0 && !send_hold
                && $urandom_range(0, 99) >= send_idle_pct) begin
                t_frame f;
                f = frames_to_send[0];
                {px0, px1, px2, px3, py0, py1, py2, py3} <= f;
                i_valid <= 1'b1;
            end else if (!i_valid || !o_stall) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted pose beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (poses_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected pose beat at cycle %0d", cycles);
                end else begin
                    t_pose e;
                    e = poses_due.pop_front();
                    checked++;
                    if (o_missed) missed_seen++;
                    if (e != {o_field_x, o_field_y, o_heading, o_missed}) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                     e.fx, e.fy, e.hd, e.miss,
                                     o_field_x, o_field_y, o_heading, o_missed);
                    end
                end
            end
            i_stall <= recv_hold || ($urandom_range(0, 99) < recv_idle_pct);
        end
        if (cycles > CycleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic drain();
        wait (frames_to_send.size() == 0);
        while (poses_due.size() > 0 || i_valid) @(posedge i_clk);
    endtask

    initial begin
        t_frame f;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: held pose at reset, extremes, coincident points, ties.
        frames_to_send.push_back({8{NotSeen}});
        frames_to_send.push_back('0);
        frames_to_send.push_back({10'd0, 10'd1022, 10'd0, 10'd1022, 10'd0, 10'd0, 10'd1022, 10'd1022});
        frames_to_send.push_back({10'd1022, 10'd0, 10'd1022, 10'd0, 10'd1022, 10'd1022, 10'd0, 10'd0});
        frames_to_send.push_back({10'd512, 10'd512, 10'd100, 10'd900, 10'd384, 10'd384, 10'd50, 10'd700});
        frames_to_send.push_back({10'd512, 10'd612, 10'd512, 10'd612, 10'd384, 10'd384, 10'd484, 10'd484});
        frames_to_send.push_back({10'd0, 10'd1022, 10'd1022, 10'd0, 10'd0, 10'd1022, 10'd0, 10'd1022});
        frames_to_send.push_back({10'd1022, 10'd1022, 10'd1022, 10'd1022, 10'd1022, 10'd1022, 10'd1022, 10'd1022});
        frames_to_send.push_back({10'd200, 10'd100, 10'd300, 10'd100, 10'd600, 10'd600, 10'd600, 10'd100});
        frames_to_send.push_back({10'd1023, 10'd5, 10'd6, 10'd7, 10'd5, 10'd6, 10'd7, 10'd8});
        frames_to_send.push_back({10'd5, 10'd6, 10'd7, 10'd8, 10'd5, 10'd6, 10'd7, 10'd1023});
        frames_to_send.push_back({10'd700, 10'd300, 10'd500, 10'd500, 10'd384, 10'd384, 10'd100, 10'd700});
        frames_to_send.push_back({10'd341, 10'd682, 10'd170, 10'd853, 10'd341, 10'd682, 10'd853, 10'd170});
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 26 : (phase == 1 ? 58 : 0);
            recv_idle_pct = phase == 0 ? 58 : (phase == 1 ? 26 : 0);
            for (int k = 0; k < 380; k++) begin
                f = rand_frame($urandom_range(0, 5) == 0);
                frames_to_send.push_back(f);
                if (phase == 2 && k == 100) begin
                    // Long receiver hold-off while frames keep coming.
                    recv_hold = 1'b1;
                    repeat (300) @(posedge i_clk);
                    recv_hold = 1'b0;
                end
            end
            drain();
            // Sender pause: everything due has arrived; wait out the pipeline.
            send_hold = 1'b1;
            repeat (40) @(posedge i_clk);
            send_hold = 1'b0;
        end

        repeat (60) @(posedge i_clk);
        $display("checked %0d pose beats, %0d of them missed frames, under three idle mixes",
                 checked, missed_seen);
        if (fails == 0 && poses_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d failures, %0d poses outstanding", fails, poses_due.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
